// ----- rtl/ud32_pkg.sv -----
package ud32_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic                  divide_by_zero;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture operands
    logic setup;   // early exits, init of the shift registers
    logic step;    // one restoring step
    logic commit;  // move result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;     // result known without iterating
    logic out_free;  // output register can take a beat this cycle
  } stat_t;

endpackage

// ----- rtl/unsigned_divider_32_unit.sv -----
// unsigned 32-bit divider, restoring shift-subtract, one quotient bit per cycle
//
// input channel: in_valid / in_stall / in_data (dividend, divisor)
// output channel: out_valid / out_stall / out_data (quotient, divide_by_zero)
// a beat moves at a rising edge with valid high and stall low
//
// one division at a time: in_stall is high from the cycle after a beat is
// taken until its result has gone into the output register
// from input beat to output valid:
//   when the result is known at setup (zero divisor, zero dividend,
//   divisor above dividend, divisor of one): setup, then the write of
//   the output register; otherwise: setup, 32 iterations of the shared
//   subtract/shift step, then the write of the output register
// a zero divisor gives quotient 0 with divide_by_zero set
//
// while out_stall holds a result, the next division is still taken and runs;
// it waits in its last state until the output register frees
// reset (rst, synchronous) returns the controller to idle and drops out_valid
module unsigned_divider_32_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ud32_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ud32_pkg::out_t  out_data
);

  // command and status between sequencer and datapath
  ud32_pkg::cmd_t  cmd;
  ud32_pkg::stat_t stat;

  // sequencer: idle, setup, iterate, hand off
  ud32_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // operand, remainder and quotient registers plus the output register
  ud32_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/ud32_dp.sv -----
module ud32_dp (
  input  logic              clk,
  input  logic              rst,
  input  ud32_pkg::in_t     in_data,
  input  ud32_pkg::cmd_t    cmd,
  output ud32_pkg::stat_t   stat,
  output logic              out_valid,
  input  logic              out_stall,
  output ud32_pkg::out_t    out_data
);

  logic [ud32_pkg::DATA_WIDTH-1:0] num;
  logic [ud32_pkg::DATA_WIDTH-1:0] den;
  logic [ud32_pkg::DATA_WIDTH-1:0] rem;
  logic [ud32_pkg::DATA_WIDTH-1:0] quo;
  logic                            dz;

  logic                            den_zero;
  logic                            num_zero;
  logic                            den_one;
  logic                            den_gt;
  logic [ud32_pkg::DATA_WIDTH-1:0] early_quo;
  logic [ud32_pkg::DATA_WIDTH:0]   rem_sh;
  logic [ud32_pkg::DATA_WIDTH:0]   diff;

  assign den_zero = (den == '0);
  assign num_zero = (num == '0);
  assign den_one  = (den == ud32_pkg::DATA_WIDTH'(1));
  assign den_gt   = (den > num);

  always_comb begin
    if (den_zero || num_zero || den_gt) begin
      early_quo = '0;
    end else begin
      early_quo = num;
    end
  end

  // shift in the next dividend bit, trial subtract
  assign rem_sh = {rem, quo[ud32_pkg::DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, den};

  assign stat.early    = den_zero || num_zero || den_gt || den_one;
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= in_data.dividend;
      den <= in_data.divisor;
    end
    if (cmd.setup) begin
      rem <= '0;
      dz  <= den_zero;
      if (stat.early) begin
        quo <= early_quo;
      end else begin
        quo <= num;
      end
    end else if (cmd.step) begin
      if (!diff[ud32_pkg::DATA_WIDTH]) begin
        rem <= diff[ud32_pkg::DATA_WIDTH-1:0];
        quo <= {quo[ud32_pkg::DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_sh[ud32_pkg::DATA_WIDTH-1:0];
        quo <= {quo[ud32_pkg::DATA_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.commit) begin
      out_data.quotient       <= quo;
      out_data.divide_by_zero <= dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // partial remainder stays below the divisor while iterating
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.step) |-> (rem < den))
    else $error("partial remainder not below divisor");

  // a zero divisor always comes out with a zero quotient
  a_dz_zero_quo: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_by_zero |-> (out_data.quotient == '0))
    else $error("divide by zero with nonzero quotient");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

// ----- rtl/ud32_ctrl.sv -----
module ud32_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ud32_pkg::stat_t   stat,
  output ud32_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SETUP,
    RUN,
    FINISH
  } state_t;

  state_t                     state;
  logic [ud32_pkg::CNT_W-1:0] cnt;

  assign in_stall   = (state != IDLE);
  assign cmd.load   = (state == IDLE) && in_valid;
  assign cmd.setup  = (state == SETUP);
  assign cmd.step   = (state == RUN);
  assign cmd.commit = (state == FINISH) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= SETUP;
          end
        end
        SETUP: begin
          cnt <= ud32_pkg::CNT_W'(ud32_pkg::DATA_WIDTH - 1);
          if (stat.early) begin
            state <= FINISH;
          end else begin
            state <= RUN;
          end
        end
        RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_accept_to_setup: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> cmd.setup)
    else $error("accepted beat not followed by setup");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit while output register is full");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) && (cnt != '0) |=> (state == RUN) && (cnt == $past(cnt) - 1'b1))
    else $error("iteration counter out of step");

endmodule
